@@ rtl/encoder_period_speed_controller_core_defines.svh @@
// Assertion macros for the encoder period speed controller.
// Used by the core module; needs nothing else.
`ifndef ENCODER_PERIOD_SPEED_CONTROLLER_CORE_DEFINES_SVH
`define ENCODER_PERIOD_SPEED_CONTROLLER_CORE_DEFINES_SVH

// same-cycle implication, gated off in reset
`define EPSC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, gated off in reset
`define EPSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/epsc_pkg.sv @@
// Shared constants for the encoder period speed controller.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package epsc_pkg;

  localparam int TIME_BITS_DEF = 48;

  localparam int TARGET_W = 8;
  localparam int GAIN_W   = 10;
  localparam int SCALE_W  = 24;
  localparam int A_W      = GAIN_W + TARGET_W;   // gain*target
  localparam int MUL_W    = GAIN_W + SCALE_W;    // gain*scale
  localparam int CNT_W    = $clog2(MUL_W);
  localparam int DUTY_W   = 16;

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_TARGET = 2'd0;
  localparam logic [1:0] REG_GAIN   = 2'd1;
  localparam logic [1:0] REG_SCALE  = 2'd2;

  localparam logic [TARGET_W-1:0] TARGET_RST = 8'd50;
  localparam logic [GAIN_W-1:0]   GAIN_RST   = 10'd300;
  localparam logic [SCALE_W-1:0]  SCALE_RST  = 24'd500000;
  localparam logic [DUTY_W-1:0]   DUTY_MAX   = 16'hFFFF;

endpackage

`default_nettype wire

@@ rtl/encoder_period_speed_controller_core.sv @@
// Encoder period speed controller: proportional duty from rising-edge interval.
// Depends on epsc_pkg and encoder_period_speed_controller_core_defines.svh.
//
//  channel   dir  signals                        beat content
//  s_*       in   s_tvalid/s_tready/s_tdata      pin sample + timestamp
//  m_*       out  m_tvalid/m_tready/m_tdata      duty, update flag, level
//  apb       in   psel/penable/pwrite/paddr/...  target, gain, scale regs
//
// A sample that is not a rising edge gives its result in the cycle after accept.
// A rising edge runs two multiplies on one shared multiplier, then a 34-step
// restoring divide (one quotient bit a cycle), and ST_DONE registers the result.
// s_tready is low while the sequencer runs or the output register is full and m_tready is low.
// rst is synchronous; it restores the register defaults and a duty of 65535.
`timescale 1ns / 1ps
`default_nettype none
`include "encoder_period_speed_controller_core_defines.svh"

module encoder_period_speed_controller_core #(
  parameter int TIME_BITS = epsc_pkg::TIME_BITS_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst,
  // s_tdata: [0] pin_level, [TIME_BITS:1] time_us, zero pad to bytes
  input  wire                                   s_tvalid,
  output logic                                  s_tready,
  input  wire  [((TIME_BITS + 1 + 7) / 8)*8-1:0] s_tdata,
  // m_tdata: [15:0] duty_level, [16] duty_updated, [17] level_echo, zero pad
  output logic                                  m_tvalid,
  input  wire                                   m_tready,
  output logic [23:0]                           m_tdata,
  input  wire                                   psel,
  input  wire                                   penable,
  input  wire                                   pwrite,
  input  wire  [epsc_pkg::APB_AW-1:0]           paddr,
  input  wire  [epsc_pkg::APB_DW-1:0]           pwdata,
  output logic [epsc_pkg::APB_DW-1:0]           prdata,
  output logic                                  pready
);

  localparam int MUL_W  = epsc_pkg::MUL_W;
  localparam int A_W    = epsc_pkg::A_W;
  localparam int CNT_W  = epsc_pkg::CNT_W;
  localparam int DUTY_W = epsc_pkg::DUTY_W;
  localparam int Q_W    = MUL_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULA,
    ST_MULB,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t state;

  logic [epsc_pkg::TARGET_W-1:0] target_speed;
  logic [epsc_pkg::GAIN_W-1:0]   gain;
  logic [epsc_pkg::SCALE_W-1:0]  speed_scale;

  logic                 previous_level;
  logic [TIME_BITS-1:0] previous_edge_time;
  logic [DUTY_W-1:0]    held_duty;

  logic [TIME_BITS-1:0] dt;
  logic [A_W-1:0]       prod_a;
  logic [MUL_W-1:0]     quo;
  logic [TIME_BITS-1:0] rem;
  logic [CNT_W-1:0]     cnt;
  logic                 cur_level;

  logic [DUTY_W-1:0]    out_duty;
  logic                 out_updated;
  logic                 out_level;

  // ---------------- APB ----------------
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[3:2])
      epsc_pkg::REG_TARGET: prdata = 32'(target_speed);
      epsc_pkg::REG_GAIN:   prdata = 32'(gain);
      epsc_pkg::REG_SCALE:  prdata = 32'(speed_scale);
      default:              prdata = '0;
    endcase
  end

  // ---------------- input decode ----------------
  logic                 s_fire;
  logic                 in_level;
  logic [TIME_BITS-1:0] in_time;
  logic                 is_edge;
  logic                 out_load;

  assign s_tready = (state == ST_IDLE) && (!m_tvalid || m_tready);
  assign s_fire   = s_tvalid && s_tready;
  assign in_level = s_tdata[0];
  assign in_time  = s_tdata[TIME_BITS:1];
  assign is_edge  = !previous_level && in_level;
  // output register takes a new beat this cycle
  assign out_load = (state == ST_DONE) || (s_fire && !is_edge);

  // ---------------- shared multiplier ----------------
  logic [epsc_pkg::SCALE_W-1:0] mul_op;
  logic [MUL_W-1:0]             mul_res;

  assign mul_op  = (state == ST_MULA) ? epsc_pkg::SCALE_W'(target_speed) : speed_scale;
  assign mul_res = MUL_W'(gain) * MUL_W'(mul_op);

  // ---------------- divide step ----------------
  logic [TIME_BITS:0]   rem_sh;
  logic [TIME_BITS:0]   rem_diff;
  logic                 rem_ge;
  logic [TIME_BITS-1:0] rem_next;
  logic [MUL_W-1:0]     quo_next;

  assign rem_sh   = {rem, quo[MUL_W-1]};
  assign rem_diff = rem_sh - {1'b0, dt};
  assign rem_ge   = rem_sh >= {1'b0, dt};
  assign rem_next = rem_ge ? rem_diff[TIME_BITS-1:0] : rem_sh[TIME_BITS-1:0];
  assign quo_next = {quo[MUL_W-2:0], rem_ge};

  // ---------------- final saturation ----------------
  logic [Q_W-1:0]    ceil_q;
  logic [Q_W-1:0]    a_ext;
  logic [Q_W-1:0]    duty_diff;
  logic [DUTY_W-1:0] duty_next;

  assign ceil_q    = {1'b0, quo} + Q_W'(rem != '0);
  assign a_ext     = Q_W'(prod_a);
  assign duty_diff = a_ext - ceil_q;

  always_comb begin
    if ((dt == '0) || (ceil_q >= a_ext)) begin
      duty_next = '0;
    end else if (duty_diff > Q_W'(epsc_pkg::DUTY_MAX)) begin
      duty_next = epsc_pkg::DUTY_MAX;
    end else begin
      duty_next = duty_diff[DUTY_W-1:0];
    end
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      m_tvalid           <= 1'b0;
      target_speed       <= epsc_pkg::TARGET_RST;
      gain               <= epsc_pkg::GAIN_RST;
      speed_scale        <= epsc_pkg::SCALE_RST;
      previous_level     <= 1'b0;
      previous_edge_time <= '0;
      held_duty          <= epsc_pkg::DUTY_MAX;
    end else begin
      if (cfg_wr) begin
        case (paddr[3:2])
          epsc_pkg::REG_TARGET: target_speed <= pwdata[epsc_pkg::TARGET_W-1:0];
          epsc_pkg::REG_GAIN:   gain         <= pwdata[epsc_pkg::GAIN_W-1:0];
          epsc_pkg::REG_SCALE:  speed_scale  <= pwdata[epsc_pkg::SCALE_W-1:0];
          default: ;
        endcase
      end

      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (s_fire) begin
            previous_level <= in_level;
            cur_level      <= in_level;
            if (is_edge) begin
              dt                 <= in_time - previous_edge_time;
              previous_edge_time <= in_time;
              state              <= ST_MULA;
            end else begin
              out_duty    <= held_duty;
              out_updated <= 1'b0;
              out_level   <= in_level;
            end
          end
        end
        ST_MULA: begin
          prod_a <= mul_res[A_W-1:0];
          state  <= ST_MULB;
        end
        ST_MULB: begin
          quo   <= mul_res;
          rem   <= '0;
          cnt   <= CNT_W'(MUL_W - 1);
          state <= ST_DIV;
        end
        ST_DIV: begin
          quo <= quo_next;
          rem <= rem_next;
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          held_duty   <= duty_next;
          out_duty    <= duty_next;
          out_updated <= 1'b1;
          out_level   <= cur_level;
          state       <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tdata = {6'b0, out_level, out_updated, out_duty};

  // ---------------- assertions ----------------
  `EPSC_ASSERT_NEXT(a_edge_starts_seq, clk, rst, s_fire && is_edge,
    state == ST_MULA, "rising edge did not start the sequencer")
  `EPSC_ASSERT_NEXT(a_plain_keeps_duty, clk, rst, s_fire && !is_edge,
    $stable(held_duty) && m_tvalid && !out_updated, "non-edge sample changed duty")
  `EPSC_ASSERT_NOW(a_busy_not_ready, clk, rst, state != ST_IDLE,
    !s_tready, "input accepted while sequencer busy")
  `EPSC_ASSERT_NOW(a_out_empty_in_seq, clk, rst, state == ST_DONE,
    !m_tvalid, "output register full when duty result lands")
  `EPSC_ASSERT_NEXT(a_done_updates, clk, rst, state == ST_DONE,
    m_tvalid && out_updated && (out_duty == held_duty), "edge result not flagged")

endmodule

`default_nettype wire
